@@ sv/assert_macros.svh @@
// Assertion macros shared by the queue RTL modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ sv/sqs_pkg.sv @@
// Package for the shifting queue with search: field widths, codes and
// the command struct between controller and datapath. Depends on nothing.
`default_nettype none

package sqs_pkg;

    // Built number of queue cells; the count and position widths below cover it.
    localparam int unsigned DEPTH = 16;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic capture;   // latch the incoming word
        logic execute;   // apply the operation to the queue
        logic load_out;  // load the result register
    } ctl_cmd_t;

endpackage

`default_nettype wire

@@ sv/sqs_if.sv @@
// Handshake channel interfaces of the queue: operation words in and
// result words out. Depends on sqs_pkg.
`default_nettype none

interface sqs_in_if
    import sqs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sqs_out_if
    import sqs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] popped_value;
    logic [POS_W-1:0]         found_position;
    logic [CNT_W-1:0]         item_count;
    logic                     is_full;
    logic                     is_empty;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;

    modport source (output valid, output status, output popped_value,
                    output found_position, output item_count, output is_full,
                    output is_empty, output head_value, output tail_value,
                    input ready);
    modport sink   (input valid, input status, input popped_value,
                    input found_position, input item_count, input is_full,
                    input is_empty, input head_value, input tail_value,
                    output ready);
endinterface

`default_nettype wire

@@ sv/shifting_queue_with_search_unit.sv @@
// Top level of the shifting queue with search: sequencer plus datapath.
// Depends on sqs_pkg, sqs_if, sqs_ctrl and sqs_dp.
`default_nettype none

// Channel     Dir  Handshake        Word contents
// in_word     in   valid / ready    op, value
// out_result  out  valid / ready    status, popped_value, found_position,
//                                   item_count, is_full, is_empty,
//                                   head_value, tail_value
// cfg         in   cfg_we           cfg_wdata (capacity)
//
// Each word passes three steps: accept, execute, result load. A new word is
// accepted only once the last one is loaded; the three-state sequencer sets this.
// Reset clears the count and sets capacity to 16; cells are not cleared and
// need no clearing pass, since only positions below the count are read.
// While a result waits on out_result, the next word is still accepted and
// executed; it then holds in the load step until the result register frees.
module shifting_queue_with_search_unit
    import sqs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    sqs_in_if.sink                in_word,
    sqs_out_if.source             out_result
);

    // Commands from the sequencer to the datapath.
    ctl_cmd_t cmd;

    // The sequencer owns both handshakes and the result valid flag.
    sqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_word.valid),
        .in_ready  (in_word.ready),
        .out_valid (out_result.valid),
        .out_ready (out_result.ready),
        .cmd       (cmd)
    );

    // The datapath holds the cells, the count, the capacity and the result.
    sqs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_op          (in_word.op),
        .in_value       (in_word.value),
        .status         (out_result.status),
        .popped_value   (out_result.popped_value),
        .found_position (out_result.found_position),
        .item_count     (out_result.item_count),
        .is_full        (out_result.is_full),
        .is_empty       (out_result.is_empty),
        .head_value     (out_result.head_value),
        .tail_value     (out_result.tail_value)
    );

endmodule

`default_nettype wire

@@ sv/sqs_ctrl.sv @@
// Sequencer of the queue: accept, execute and result load per word.
// Depends on sqs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sqs_ctrl
    import sqs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output ctl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // The result register can take a new word when empty or drained now.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `SQS_ASSERT_IMPL(a_load_into_free_slot, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready)
    `SQS_ASSERT_NEXT(a_accept_then_exec, clk, rst_n, in_valid && in_ready, state_reg == S_EXEC)
    `SQS_ASSERT_NEXT(a_exec_then_load, clk, rst_n, state_reg == S_EXEC, state_reg == S_LOAD)

endmodule

`default_nettype wire

@@ sv/sqs_dp.sv @@
// Datapath of the queue: shifting cells, count, capacity register,
// parallel key compare with priority encoder, and the result register.
// Depends on sqs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sqs_dp
    import sqs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ctl_cmd_t                 cmd,
    input  wire logic                     cfg_we,
    input  wire logic [CNT_W-1:0]         cfg_wdata,
    input  wire logic [OP_W-1:0]          in_op,
    input  wire logic signed [DATA_W-1:0] in_value,
    output logic [STAT_W-1:0]             status,
    output logic signed [DATA_W-1:0]      popped_value,
    output logic [POS_W-1:0]              found_position,
    output logic [CNT_W-1:0]              item_count,
    output logic                          is_full,
    output logic                          is_empty,
    output logic signed [DATA_W-1:0]      head_value,
    output logic signed [DATA_W-1:0]      tail_value
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic signed [DATA_W-1:0] cells_reg [DEPTH];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         capacity_reg;
    logic [OP_W-1:0]          op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [STAT_W-1:0]        res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_popped_reg, res_popped_next;
    logic [POS_W-1:0]         res_pos_reg, res_pos_next;

    logic [STAT_W-1:0]        status_reg;
    logic signed [DATA_W-1:0] popped_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         count_out_reg;
    logic                     full_reg;
    logic                     empty_reg;
    logic signed [DATA_W-1:0] head_reg;
    logic signed [DATA_W-1:0] tail_reg;

    logic [CNT_W-1:0] eff_cap;
    logic             at_cap;
    logic [DEPTH-1:0] match;
    logic             found;
    logic [POS_W-1:0] found_pos;
    logic [CNT_W-1:0] tail_sel;

    // Capacity above the built depth saturates at the depth.
    assign eff_cap = (capacity_reg > DEPTH_CNT) ? DEPTH_CNT : capacity_reg;
    assign at_cap  = (count_reg >= eff_cap);

    // Compare every held cell against the key at once.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (cells_reg[i] == value_reg) && (CNT_W'(i) < count_reg);
        end
    end

    // Lowest matching position wins.
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found     = 1'b1;
                found_pos = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        res_status_next = ST_OK;
        res_popped_next = '0;
        res_pos_next    = '0;
        case (op_reg)
            OP_PUSH:
            begin
                if (at_cap)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    res_popped_next = cells_reg[0];
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            OP_FIND:
            begin
                if (found)
                begin
                    res_pos_next = found_pos;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // Query and unused codes leave the queue as it is.
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (cmd.execute)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Cell storage: push writes at the count, pop shifts toward the head.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if ((op_reg == OP_PUSH) && !at_cap)
            begin
                cells_reg[count_reg[IDX_W-1:0]] <= value_reg;
            end
            else if ((op_reg == OP_POP) && (count_reg != '0))
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    cells_reg[i] <= cells_reg[i + 1];
                end
            end
        end
    end

    assign tail_sel = count_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        if (cmd.execute)
        begin
            res_status_reg <= res_status_next;
            res_popped_reg <= res_popped_next;
            res_pos_reg    <= res_pos_next;
        end
        if (cmd.load_out)
        begin
            status_reg    <= res_status_reg;
            popped_reg    <= res_popped_reg;
            pos_reg       <= res_pos_reg;
            count_out_reg <= count_reg;
            full_reg      <= at_cap;
            empty_reg     <= (count_reg == '0);
            head_reg      <= (count_reg == '0) ? '0 : cells_reg[0];
            tail_reg      <= (count_reg == '0) ? '0 : cells_reg[tail_sel[IDX_W-1:0]];
        end
    end

    assign status         = status_reg;
    assign popped_value   = popped_reg;
    assign found_position = pos_reg;
    assign item_count     = count_out_reg;
    assign is_full        = full_reg;
    assign is_empty       = empty_reg;
    assign head_value     = head_reg;
    assign tail_value     = tail_reg;

    `SQS_ASSERT_IMPL(a_count_in_depth, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)
    `SQS_ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.execute && (op_reg == OP_PUSH) && !at_cap, count_reg == $past(count_reg) + CNT_W'(1))
    `SQS_ASSERT_NEXT(a_empty_reads_zero, clk, rst_n, cmd.load_out && (count_reg == '0), empty_reg && (head_reg == '0) && (tail_reg == '0))

endmodule

`default_nettype wire

@@ dv/queue_checker.sv @@
// Checker for the shifting queue with search: watches both channels and the
// capacity port, predicts each result word and compares it field by field.
// Depends on sqs_pkg and the channel interfaces in sqs_if.
`timescale 1ns / 100ps

module queue_checker
    import sqs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    sqs_in_if                     in_word,
    sqs_out_if                    out_result,
    output int unsigned           error_count,
    output int unsigned           pending_count
);

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] popped_value;
        logic [POS_W-1:0]         found_position;
        logic [CNT_W-1:0]         item_count;
        logic                     is_full;
        logic                     is_empty;
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] tail_value;
    } queue_result_t;

    logic signed [DATA_W-1:0] queue_cells [DEPTH];
    int unsigned              cell_count;
    logic [CNT_W-1:0]         capacity_reg;
    queue_result_t            awaited_results [$];
    int unsigned              mismatch_total;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("checker: %0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_total++;
    endtask

    // Applies one operation word to the shadow queue and returns the result
    // word that the block must produce for it.
    function automatic queue_result_t apply_queue_op(input logic [OP_W-1:0] op,
                                                     input logic signed [DATA_W-1:0] key);
        queue_result_t r;
        int unsigned   limit;
        bit            hit;
        r     = '0;
        hit   = 1'b0;
        limit = (capacity_reg > DEPTH) ? DEPTH : 32'(capacity_reg);
        case (op)
            OP_PUSH:
                if (cell_count >= limit)
                    r.status = ST_FULL;
                else
                begin
                    queue_cells[cell_count] = key;
                    cell_count++;
                end
            OP_POP:
                if (cell_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped_value = queue_cells[0];
                    for (int i = 0; i + 1 < cell_count; i++)
                        queue_cells[i] = queue_cells[i + 1];
                    cell_count--;
                end
            OP_FIND:
            begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < cell_count; i++)
                    if (!hit && queue_cells[i] == key)
                    begin
                        hit              = 1'b1;
                        r.status         = ST_OK;
                        r.found_position = POS_W'(i);
                    end
            end
            OP_CLEAR:
                cell_count = 0;
            default:
                ;
        endcase
        r.item_count = CNT_W'(cell_count);
        r.is_full    = (cell_count >= limit);
        r.is_empty   = (cell_count == 0);
        r.head_value = (cell_count != 0) ? queue_cells[0] : '0;
        r.tail_value = (cell_count != 0) ? queue_cells[cell_count - 1] : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        queue_result_t seen;
        queue_result_t want;
        if (!rst_n)
        begin
            cell_count     = 0;
            capacity_reg   = CAP_RESET;
            mismatch_total = 0;
            awaited_results.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_result.valid && out_result.ready)
            begin
                seen.status         = out_result.status;
                seen.popped_value   = out_result.popped_value;
                seen.found_position = out_result.found_position;
                seen.item_count     = out_result.item_count;
                seen.is_full        = out_result.is_full;
                seen.is_empty       = out_result.is_empty;
                seen.head_value     = out_result.head_value;
                seen.tail_value     = out_result.tail_value;
                if (awaited_results.size() == 0)
                    report_mismatch("result word with none awaited",
                                    DATA_W'(seen.item_count), '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch("status", DATA_W'(seen.status),
                                        DATA_W'(want.status));
                    if (seen.popped_value !== want.popped_value)
                        report_mismatch("popped_value", seen.popped_value, want.popped_value);
                    if (seen.found_position !== want.found_position)
                        report_mismatch("found_position", DATA_W'(seen.found_position),
                                        DATA_W'(want.found_position));
                    if (seen.item_count !== want.item_count)
                        report_mismatch("item_count", DATA_W'(seen.item_count),
                                        DATA_W'(want.item_count));
                    if (seen.is_full !== want.is_full)
                        report_mismatch("is_full", DATA_W'(seen.is_full),
                                        DATA_W'(want.is_full));
                    if (seen.is_empty !== want.is_empty)
                        report_mismatch("is_empty", DATA_W'(seen.is_empty),
                                        DATA_W'(want.is_empty));
                    if (seen.head_value !== want.head_value)
                        report_mismatch("head_value", seen.head_value, want.head_value);
                    if (seen.tail_value !== want.tail_value)
                        report_mismatch("tail_value", seen.tail_value, want.tail_value);
                end
            end
            if (cfg_we)
                capacity_reg = cfg_wdata;
            if (in_word.valid && in_word.ready)
                awaited_results.push_back(apply_queue_op(in_word.op, in_word.value));
            error_count   <= mismatch_total;
            pending_count <= awaited_results.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the queue testbench: clock, reset, stimulus and the verdict.
// Depends on sqs_pkg, sqs_if, the queue RTL and queue_checker.
`timescale 1ns / 100ps

module testbench;
    import sqs_pkg::*;

    localparam int unsigned QUEUE_DEPTH = DEPTH;
    localparam int unsigned RANDOM_WORDS = 1750;
    localparam int unsigned CALM_WORDS = 80;

    // Operation codes without a name in the package; the block treats them as
    // a query.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_ALL_ONES = -32'sd1;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    int unsigned      error_count;
    int unsigned      pending_count;

    // Chance in percent that either side starts an idle burst; zero gives a
    // stretch with no idling at all.
    int unsigned stall_pct;
    int unsigned ready_hold;

    // A small set of words per phase, so that finds hit queued entries often.
    logic signed [DATA_W-1:0] key_pool [8];

    sqs_in_if  in_word ();
    sqs_out_if out_result ();

    shifting_queue_with_search_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_word    (in_word),
        .out_result (out_result)
    );

    queue_checker #(
        .DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_word       (in_word),
        .out_result    (out_result),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result side stalls in bursts. A burst starts with the chance that the
    // current phase sets and holds ready low for the drawn number of cycles.
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            out_result.ready <= 1'b0;
            ready_hold       <= ready_hold - 1;
        end
        else if ($urandom_range(99, 0) < stall_pct)
        begin
            out_result.ready <= 1'b0;
            ready_hold       <= $urandom_range(12, 0);
        end
        else
            out_result.ready <= 1'b1;
    end

    // Offers one operation word and returns at the edge that accepts it. An
    // idle burst may come first. Valid is left high, so that back-to-back
    // words keep it high without a dip.
    task automatic send_word(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
        if ($urandom_range(99, 0) < stall_pct)
        begin
            in_word.valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge clk);
        end
        in_word.valid <= 1'b1;
        in_word.op    <= op;
        in_word.value <= value;
        @(posedge clk);
        while (!in_word.ready) @(posedge clk);
    endtask

    // Stops offering words and waits until the checker holds no expected
    // result. The checker's count is registered, hence the first edge here.
    task automatic wait_drained();
        in_word.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // The capacity is only written while the block is idle. Every word yields
    // one result, so an empty expectation store means the block has finished.
    task automatic write_capacity(input logic [CNT_W-1:0] capacity);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= capacity;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 60)
            return key_pool[$urandom_range(7, 0)];
        else if (sel < 85)
            return $urandom;
        else
            case ($urandom_range(4, 0))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return WORD_ALL_ONES;
                3:       return '0;
                default: return 32'sd1;
            endcase
    endfunction

    // Mostly pushes, pops and finds; the push share sets whether the queue
    // tends to fill up or to run dry during a phase.
    task automatic send_random_word(input int unsigned push_pct);
        logic [OP_W-1:0] op;
        int unsigned     sel;
        if ($urandom_range(99, 0) < push_pct)
            op = OP_PUSH;
        else
        begin
            sel = $urandom_range(99, 0);
            if (sel < 50)
                op = OP_POP;
            else if (sel < 80)
                op = OP_FIND;
            else if (sel < 86)
                op = OP_QUERY;
            else if (sel < 89)
                op = OP_CLEAR;
            else
                op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        send_word(op, pick_value());
    endtask

    initial
    begin
        int unsigned      words_sent;
        int unsigned      phase;
        int unsigned      phase_words;
        int unsigned      push_pct;
        logic [CNT_W-1:0] capacity;

        in_word.valid    = 1'b0;
        in_word.op       = OP_QUERY;
        in_word.value    = '0;
        out_result.ready = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = CAP_RESET;
        stall_pct        = 0;
        ready_hold       = 0;
        rst_n            = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity. An empty queue answers pop and find
        // with their refusal codes and query with OK, and the unnamed codes act as
        // a query. The value field is random where it is ignored.
        send_word(OP_QUERY, $urandom);
        send_word(OP_POP, $urandom);
        send_word(OP_FIND, '0);
        send_word(OP_SPARE_LO, $urandom);
        send_word(OP_SPARE_HI, $urandom);
        // Extreme words, with a duplicate so that find must report the lowest
        // matching position rather than any match.
        send_word(OP_PUSH, WORD_MAX);
        send_word(OP_PUSH, WORD_MIN);
        send_word(OP_PUSH, WORD_ALL_ONES);
        send_word(OP_PUSH, '0);
        send_word(OP_PUSH, WORD_MIN);
        send_word(OP_FIND, WORD_MIN);
        send_word(OP_FIND, WORD_ALL_ONES);
        send_word(OP_FIND, 32'sd1);
        send_word(OP_POP, $urandom);
        // Capacity lowered below the count: the entries stay, pushes are
        // refused and the queue reads full until pops bring it below.
        write_capacity(5'd2);
        send_word(OP_PUSH, $urandom);
        send_word(OP_POP, $urandom);
        send_word(OP_POP, $urandom);
        send_word(OP_POP, $urandom);
        // A capacity of zero refuses every push and an empty queue reads full
        // and empty at once.
        write_capacity(5'd0);
        send_word(OP_CLEAR, $urandom);
        send_word(OP_QUERY, $urandom);
        send_word(OP_PUSH, $urandom);

        // Random part in phases. Each phase writes a new capacity once the
        // block is idle, then runs a batch of words with its own push share
        // and idling rate. The queue is not cleared between phases, so a lower
        // capacity often lands below the count. The first phases walk through
        // the extreme capacities, including ones above the built depth.
        words_sent = 0;
        phase      = 0;
        while (words_sent < RANDOM_WORDS - CALM_WORDS)
        begin
            case (phase)
                0:       capacity = 5'd16;
                1:       capacity = 5'd1;
                2:       capacity = 5'd31;
                3:       capacity = 5'd0;
                4:       capacity = CNT_W'($urandom_range(30, 17));
                default:
                    case ($urandom_range(9, 0))
                        0:       capacity = 5'd0;
                        1:       capacity = 5'd1;
                        2:       capacity = 5'd16;
                        3:       capacity = CNT_W'($urandom_range(31, 17));
                        default: capacity = CNT_W'($urandom_range(15, 2));
                    endcase
            endcase
            write_capacity(capacity);
            foreach (key_pool[i])
                key_pool[i] = $urandom;
            case ($urandom_range(2, 0))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 30;
            endcase
            push_pct    = $urandom_range(75, 30);
            phase_words = $urandom_range(140, 40);
            repeat (phase_words) send_random_word(push_pct);
            words_sent += phase_words;
            phase++;
        end

        // Last stretch with no idling on either side, at full capacity.
        write_capacity(5'd16);
        stall_pct = 0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (CALM_WORDS) send_random_word(60);

        // Waiting on past the last result catches any stray extra word.
        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // About 5 ms of simulated time, several times the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/sqs_pkg.sv
sv/sqs_if.sv
sv/sqs_ctrl.sv
sv/sqs_dp.sv
sv/shifting_queue_with_search_unit.sv
dv/queue_checker.sv
dv/testbench.sv
